// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, switched off while reset is high.
`define ASSERT_CLK_RST(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Assertion sampled on the rising clock edge, also checked during reset.
`define ASSERT_CLK(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: hdl/rsq_pkg.sv
// Package for the record stack/queue unit: sizes, record type, codes,
// and the command and status bundles between controller and datapath.
// Depends on nothing.
package rsq_pkg;

   localparam int DEPTH     = 16;
   localparam int PTR_W     = $clog2(DEPTH);
   localparam int COUNT_W   = $clog2(DEPTH + 1);
   localparam int TICKET_W  = 16;
   localparam int NAME_W    = 64;
   localparam int DATE_W    = 23;

   localparam logic [PTR_W:0]     DEPTH_WIDE = (PTR_W + 1)'(DEPTH);
   localparam logic [PTR_W-1:0]   PTR_LAST   = PTR_W'(DEPTH - 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(DEPTH);

   typedef enum logic [1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_UPDATE = 2'd2,
      REQ_LIST   = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_EMPTY     = 2'd1,
      STAT_NOT_FOUND = 2'd2,
      STAT_FULL      = 2'd3
   } status_code_type;

   typedef struct packed {
      logic [TICKET_W-1:0] ticket;
      logic [NAME_W-1:0]   name;
      logic [DATE_W-1:0]   date;
   } record_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            load_req;
      logic            do_add;
      logic            do_remove;
      logic            do_update;
      logic            rd_first;
      logic            rd_next;
      logic            emit;
      logic            emit_data;
      logic            emit_last;
      status_code_type emit_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic empty;
      logic full;
      logic match;
      logic at_last;
      logic out_free;
   } dp_stat_type;

   // Circular position: base plus offset, wrapped at DEPTH.
   function automatic logic [PTR_W-1:0] slot_wrap(input logic [PTR_W-1:0] base,
                                                   input logic [PTR_W-1:0] off);
      logic [PTR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_WIDE) begin
         sum = sum - DEPTH_WIDE;
      end
      return sum[PTR_W-1:0];
   endfunction

endpackage

// File: hdl/record_stack_or_queue_with_update_unit.sv
// Record stack/queue unit. An accepted request goes from IDLE to EXEC, where add,
// remove and an update or list of an empty buffer answer into the response register.
// Update and list then walk the records from the head in SCAN through the single
// memory read port, one record per cycle; a list pauses while a beat waits.
// Reset (synchronous, active high) empties the buffer and selects stack order;
// record contents are not cleared and need no clearing pass.
module record_stack_or_queue_with_update_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_type,
   input  logic [rsq_pkg::TICKET_W-1:0] req_ticket_in,
   input  logic [rsq_pkg::NAME_W-1:0]   req_name_in,
   input  logic [rsq_pkg::DATE_W-1:0]   req_date_in,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_status,
   output logic [rsq_pkg::TICKET_W-1:0] rsp_ticket_out,
   output logic [rsq_pkg::NAME_W-1:0]   rsp_name_out,
   output logic [rsq_pkg::DATE_W-1:0]   rsp_date_out,
   output logic                         rsp_last_item
);

   // The controller decides what each cycle does; the datapath owns all record storage.
   // They talk only through the command and status bundles below.
   rsq_pkg::dp_cmd_type  cmd;
   rsq_pkg::dp_stat_type stat;

   // The controller takes one request at a time. Once the last beat of a request
   // sits in the response register, a new request can be accepted while that beat
   // still waits for the consumer; the response register keeps the two sides apart.
   rsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Records sit in a circular memory. The head is at the base pointer and the
   // rest follow at ascending positions. Stack adds move the base down one place,
   // queue adds write behind the tail, and removes always drop the head.
   // Update and list walk from the head, one read per cycle unless a list beat waits.
   rsq_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_ticket_in  (req_ticket_in),
      .req_name_in    (req_name_in),
      .req_date_in    (req_date_in),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ready),
      .rsp_valid      (rsp_valid),
      .rsp_status     (rsp_status),
      .rsp_ticket_out (rsp_ticket_out),
      .rsp_name_out   (rsp_name_out),
      .rsp_date_out   (rsp_date_out),
      .rsp_last_item  (rsp_last_item)
   );

endmodule

// File: hdl/rsq_datapath.sv
// Datapath of the record stack/queue unit: record memory, head pointer,
// record count, request latch, scan index and response register. Uses rsq_pkg.
module rsq_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic                         csr_wr_data,
   input  logic [rsq_pkg::TICKET_W-1:0] req_ticket_in,
   input  logic [rsq_pkg::NAME_W-1:0]   req_name_in,
   input  logic [rsq_pkg::DATE_W-1:0]   req_date_in,
   input  rsq_pkg::dp_cmd_type          cmd,
   output rsq_pkg::dp_stat_type         stat,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [1:0]                   rsp_status,
   output logic [rsq_pkg::TICKET_W-1:0] rsp_ticket_out,
   output logic [rsq_pkg::NAME_W-1:0]   rsp_name_out,
   output logic [rsq_pkg::DATE_W-1:0]   rsp_date_out,
   output logic                         rsp_last_item
);

   rsq_pkg::record_type mem [rsq_pkg::DEPTH];

   logic                          order_mode_ff, order_mode_in;
   logic [rsq_pkg::PTR_W-1:0]     base_ff, base_in;
   logic [rsq_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [rsq_pkg::PTR_W-1:0]     idx_ff, idx_in;
   logic [rsq_pkg::PTR_W-1:0]     rd_addr_ff, rd_addr_in;
   rsq_pkg::record_type           rd_data_ff;
   rsq_pkg::record_type           req_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff;
   logic [rsq_pkg::TICKET_W-1:0]  rsp_ticket_ff;
   logic [rsq_pkg::NAME_W-1:0]    rsp_name_ff;
   logic [rsq_pkg::DATE_W-1:0]    rsp_date_ff;
   logic                          rsp_last_ff;

   logic [rsq_pkg::PTR_W-1:0]     stack_base;
   logic [rsq_pkg::PTR_W-1:0]     add_pos;
   logic [rsq_pkg::PTR_W-1:0]     wr_addr;
   logic                          wr_en;
   logic                          rd_en;

   // Stack adds move the head one place down; queue adds go behind the tail.
   assign stack_base = (base_ff == '0) ? rsq_pkg::PTR_LAST : base_ff - rsq_pkg::PTR_W'(1);
   assign add_pos    = order_mode_ff ? rsq_pkg::slot_wrap(base_ff, count_ff[rsq_pkg::PTR_W-1:0])
                                     : stack_base;
   assign wr_en      = cmd.do_add | cmd.do_update;
   assign wr_addr    = cmd.do_add ? add_pos : rd_addr_ff;
   assign rd_en      = cmd.rd_first | cmd.rd_next;

   always_comb begin
      order_mode_in = csr_wr_en ? csr_wr_data : order_mode_ff;
      base_in       = base_ff;
      count_in      = count_ff;
      if (cmd.do_add) begin
         count_in = count_ff + rsq_pkg::COUNT_W'(1);
         if (!order_mode_ff) begin
            base_in = stack_base;
         end
      end else if (cmd.do_remove) begin
         count_in = count_ff - rsq_pkg::COUNT_W'(1);
         base_in  = rsq_pkg::slot_wrap(base_ff, rsq_pkg::PTR_W'(1));
      end
      idx_in     = idx_ff;
      rd_addr_in = rd_addr_ff;
      if (cmd.rd_first) begin
         idx_in     = '0;
         rd_addr_in = base_ff;
      end else if (cmd.rd_next) begin
         idx_in     = idx_ff + rsq_pkg::PTR_W'(1);
         rd_addr_in = rsq_pkg::slot_wrap(base_ff, idx_ff + rsq_pkg::PTR_W'(1));
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= 1'b0;
         base_ff       <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         order_mode_ff <= order_mode_in;
         base_ff       <= base_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_addr_ff <= rd_addr_in;
      if (cmd.load_req) begin
         req_ff.ticket <= req_ticket_in;
         req_ff.name   <= req_name_in;
         req_ff.date   <= req_date_in;
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.emit_status;
         rsp_last_ff   <= cmd.emit_last;
         rsp_ticket_ff <= cmd.emit_data ? rd_data_ff.ticket : '0;
         rsp_name_ff   <= cmd.emit_data ? rd_data_ff.name   : '0;
         rsp_date_ff   <= cmd.emit_data ? rd_data_ff.date   : '0;
      end
   end

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_ff;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr_in];
      end
   end

   assign stat.empty    = (count_ff == '0);
   assign stat.full     = (count_ff == rsq_pkg::COUNT_FULL);
   assign stat.match    = (rd_data_ff.ticket == req_ff.ticket);
   assign stat.at_last  = (rsq_pkg::COUNT_W'(idx_ff) == count_ff - rsq_pkg::COUNT_W'(1));
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_ticket_out = rsp_ticket_ff;
   assign rsp_name_out   = rsp_name_ff;
   assign rsp_date_out   = rsp_date_ff;
   assign rsp_last_item  = rsp_last_ff;

endmodule

// File: hdl/rsq_ctrl.sv
// Controller of the record stack/queue unit: takes a request, runs it against
// the datapath and sequences the response beats. Uses rsq_pkg.
module rsq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   input  rsq_pkg::dp_stat_type stat,
   output rsq_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   rsq_pkg::req_code_type op_ff, op_in;

   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      req_ready       = 1'b0;
      cmd             = '0;
      cmd.emit_last   = 1'b1;
      cmd.emit_status = rsq_pkg::STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               op_in        = rsq_pkg::req_code_type'(req_type);
               state_in     = ST_EXEC;
            end
         end
         ST_EXEC: begin
            unique case (op_ff)
               rsq_pkg::REQ_ADD: begin
                  if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = stat.full ? rsq_pkg::STAT_FULL : rsq_pkg::STAT_OK;
                     cmd.do_add      = !stat.full;
                     state_in        = ST_IDLE;
                  end
               end
               rsq_pkg::REQ_REMOVE: begin
                  if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = stat.empty ? rsq_pkg::STAT_EMPTY : rsq_pkg::STAT_OK;
                     cmd.do_remove   = !stat.empty;
                     state_in        = ST_IDLE;
                  end
               end
               rsq_pkg::REQ_UPDATE, rsq_pkg::REQ_LIST: begin
                  if (!stat.empty) begin
                     cmd.rd_first = 1'b1;
                     state_in     = ST_SCAN;
                  end else if (stat.out_free) begin
                     cmd.emit        = 1'b1;
                     cmd.emit_status = rsq_pkg::STAT_EMPTY;
                     state_in        = ST_IDLE;
                  end
               end
            endcase
         end
         ST_SCAN: begin
            unique case (op_ff)
               rsq_pkg::REQ_UPDATE: begin
                  if (stat.match) begin
                     if (stat.out_free) begin
                        cmd.emit      = 1'b1;
                        cmd.do_update = 1'b1;
                        state_in      = ST_IDLE;
                     end
                  end else if (stat.at_last) begin
                     if (stat.out_free) begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = rsq_pkg::STAT_NOT_FOUND;
                        state_in        = ST_IDLE;
                     end
                  end else begin
                     cmd.rd_next = 1'b1;
                  end
               end
               rsq_pkg::REQ_LIST: begin
                  if (stat.out_free) begin
                     cmd.emit      = 1'b1;
                     cmd.emit_data = 1'b1;
                     cmd.emit_last = stat.at_last;
                     if (stat.at_last) begin
                        state_in = ST_IDLE;
                     end else begin
                        cmd.rd_next = 1'b1;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

endmodule

// File: hdl/rsq_checker.sv
// Port-level checker for the record stack/queue unit, bound to the top level.
// Uses rsq_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rsq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [1:0]                   rsp_status,
   input logic [rsq_pkg::TICKET_W-1:0] rsp_ticket_out,
   input logic [rsq_pkg::NAME_W-1:0]   rsp_name_out,
   input logic [rsq_pkg::DATE_W-1:0]   rsp_date_out,
   input logic                         rsp_last_item
);

   logic mid_beat;
   logic err_beat;
   logic no_data;

   assign mid_beat = rsp_valid && !rsp_last_item;
   assign err_beat = rsp_valid && (rsp_status != rsq_pkg::STAT_OK);
   assign no_data  = (rsp_ticket_out == '0) && (rsp_name_out == '0) && (rsp_date_out == '0);

   // A response beat that is not taken stays offered.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)

   // Only a listing gives more than one beat, and all its beats are ok.
   `ASSERT_CLK_RST(a_multi_ok, clock, reset, mid_beat |-> rsp_status == rsq_pkg::STAT_OK)

   // Error beats never carry record data.
   `ASSERT_CLK_RST(a_err_zero, clock, reset, err_beat |-> no_data)

   // Reset leaves no response beat behind.
   `ASSERT_CLK(a_rst_idle, clock, $past(reset) |-> !rsp_valid)

endmodule

bind record_stack_or_queue_with_update_unit rsq_checker u_rsq_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_ticket_out (rsp_ticket_out),
   .rsp_name_out   (rsp_name_out),
   .rsp_date_out   (rsp_date_out),
   .rsp_last_item  (rsp_last_item)
);

// File: dv/rsq_tb_pkg.sv
`timescale 1ns / 100ps
// Beat types and the scoreboard for the record stack/queue unit testbench.
// Depends on rsq_pkg for sizes, the record layout and the request and status codes.
package rsq_tb_pkg;

   import rsq_pkg::*;

   typedef struct packed {
      req_code_type        kind;
      logic [TICKET_W-1:0] ticket;
      logic [NAME_W-1:0]   name;
      logic [DATE_W-1:0]   date;
   } req_beat_type;

   typedef struct packed {
      status_code_type     status;
      logic [TICKET_W-1:0] ticket;
      logic [NAME_W-1:0]   name;
      logic [DATE_W-1:0]   date;
      logic                last;
   } rsp_beat_type;

   // Keeps a private copy of the circular record store and turns every
   // accepted request into the response beats it must produce.
   class record_order_scoreboard;
      record_type   slots [DEPTH];
      int unsigned  head;
      int unsigned  fill;
      bit           queue_order;
      rsp_beat_type awaited [$];
      int unsigned  mismatches;

      function new();
         head        = 0;
         fill        = 0;
         queue_order = 1'b0;
         mismatches  = 0;
      endfunction

      function void set_order(bit q_mode);
         queue_order = q_mode;
      endfunction

      function int unsigned slot_of(int unsigned offset);
         return (head + offset) % DEPTH;
      endfunction

      function logic [TICKET_W-1:0] ticket_at(int unsigned offset);
         return slots[slot_of(offset)].ticket;
      endfunction

      function void push_status(status_code_type code);
         rsp_beat_type beat;
         beat        = '0;
         beat.status = code;
         beat.last   = 1'b1;
         awaited.push_back(beat);
      endfunction

      function void note_request(req_beat_type req);
         int unsigned  pos;
         int unsigned  i;
         bit           hit;
         rsp_beat_type beat;
         case (req.kind)
            REQ_ADD: begin
               if (fill >= DEPTH) begin
                  push_status(STAT_FULL);
               end else begin
                  // Stack order grows downward in front of the head.
                  if (!queue_order) begin
                     head = (head + DEPTH - 1) % DEPTH;
                     pos  = head;
                  end else begin
                     pos = slot_of(fill);
                  end
                  slots[pos].ticket = req.ticket;
                  slots[pos].name   = req.name;
                  slots[pos].date   = req.date;
                  fill++;
                  push_status(STAT_OK);
               end
            end
            REQ_REMOVE: begin
               if (fill == 0) begin
                  push_status(STAT_EMPTY);
               end else begin
                  head = slot_of(1);
                  fill--;
                  push_status(STAT_OK);
               end
            end
            REQ_UPDATE: begin
               if (fill == 0) begin
                  push_status(STAT_EMPTY);
               end else begin
                  hit = 1'b0;
                  for (i = 0; i < fill; i++) begin
                     pos = slot_of(i);
                     if (!hit && slots[pos].ticket == req.ticket) begin
                        slots[pos].name = req.name;
                        slots[pos].date = req.date;
                        hit = 1'b1;
                     end
                  end
                  push_status(hit ? STAT_OK : STAT_NOT_FOUND);
               end
            end
            default: begin
               if (fill == 0) begin
                  push_status(STAT_EMPTY);
               end else begin
                  for (i = 0; i < fill; i++) begin
                     pos         = slot_of(i);
                     beat.status = STAT_OK;
                     beat.ticket = slots[pos].ticket;
                     beat.name   = slots[pos].name;
                     beat.date   = slots[pos].date;
                     beat.last   = (i + 1 == fill);
                     awaited.push_back(beat);
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(rsp_beat_type got);
         rsp_beat_type want;
         if (awaited.size() == 0) begin
            $error("response beat arrived with no beat expected");
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         compare_field("status", want.status, got.status);
         compare_field("ticket_out", want.ticket, got.ticket);
         compare_field("name_out", want.name, got.name);
         compare_field("date_out", want.date, got.date);
         compare_field("last_item", want.last, got.last);
      endfunction
   endclass

endpackage

// File: dv/tb_record_stack_or_queue_with_update_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for record_stack_or_queue_with_update_unit.
// Depends on rsq_pkg and rsq_tb_pkg; drives directed then random requests in both orders.
module tb_record_stack_or_queue_with_update_unit;

   import rsq_pkg::*;
   import rsq_tb_pkg::*;

   // The longest request is a list of a full buffer; the settle pause after the
   // last response beat is sized from DEPTH to cover such a list.
   localparam int unsigned SETTLE_CYCLES   = 2 * DEPTH + 8;
   localparam int unsigned RSP_HOLD_CYCLES = 300;
   localparam int unsigned IDLE_LIMIT      = 3000;
   localparam int unsigned PHASE_ITEMS     = 72;

   // Cumulative request mix per traffic profile: filling, draining, mixed.
   localparam int unsigned ADD_UPTO [3] = '{65, 15, 35};
   localparam int unsigned REM_UPTO [3] = '{75, 70, 60};
   localparam int unsigned UPD_UPTO [3] = '{90, 85, 85};

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                csr_wr_en      = 1'b0;
   logic                csr_wr_data    = 1'b0;
   logic                req_valid      = 1'b0;
   logic                req_ready;
   logic [1:0]          req_type       = '0;
   logic [TICKET_W-1:0] req_ticket_in  = '0;
   logic [NAME_W-1:0]   req_name_in    = '0;
   logic [DATE_W-1:0]   req_date_in    = '0;
   logic                rsp_valid;
   logic                rsp_ready      = 1'b0;
   logic [1:0]          rsp_status;
   logic [TICKET_W-1:0] rsp_ticket_out;
   logic [NAME_W-1:0]   rsp_name_out;
   logic [DATE_W-1:0]   rsp_date_out;
   logic                rsp_last_item;

   record_order_scoreboard board;

   // no_idle turns off all gaps on both channels for one phase; hold_rsp asks
   // the response side for one long hold-off while requests keep coming.
   bit          no_idle  = 1'b0;
   bit          hold_rsp = 1'b0;
   int unsigned quiet_cycles = 0;

   always #1 clock = ~clock;

   record_stack_or_queue_with_update_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_ticket_in  (req_ticket_in),
      .req_name_in    (req_name_in),
      .req_date_in    (req_date_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_ticket_out (rsp_ticket_out),
      .rsp_name_out   (rsp_name_out),
      .rsp_date_out   (rsp_date_out),
      .rsp_last_item  (rsp_last_item)
   );

   // Gap lengths: mostly none, often short, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (no_idle || roll < 55) begin
         return 0;
      end else if (roll < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Offers one request beat, holds it until the block takes it, tells the
   // scoreboard, then maybe drops valid for a random gap. All drives happen
   // on a rising edge with nonblocking assignments.
   task automatic send_request(input req_beat_type req);
      int unsigned gap;
      req_valid     <= 1'b1;
      req_type      <= req.kind;
      req_ticket_in <= req.ticket;
      req_name_in   <= req.name;
      req_date_in   <= req.date;
      do @(posedge clock); while (!req_ready);
      board.note_request(req);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(input req_code_type kind, input logic [TICKET_W-1:0] ticket,
                              input logic [NAME_W-1:0] name, input logic [DATE_W-1:0] date);
      req_beat_type req;
      req.kind   = kind;
      req.ticket = ticket;
      req.name   = name;
      req.date   = date;
      send_request(req);
   endtask

   // Stops offering, waits for every expected response beat, then lets the
   // block run out any work still in flight before the mode may change.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.awaited.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_order(input bit q_mode);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= q_mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      board.set_order(q_mode);
   endtask

   // Random request under a traffic profile. Tickets come from a small pool
   // half the time so that duplicates and update hits are common, and most
   // updates search for a ticket that is really stored.
   function automatic req_beat_type random_request(input int unsigned profile);
      req_beat_type req;
      int unsigned  roll;
      roll = $urandom_range(0, 99);
      if (roll < ADD_UPTO[profile]) begin
         req.kind = REQ_ADD;
      end else if (roll < REM_UPTO[profile]) begin
         req.kind = REQ_REMOVE;
      end else if (roll < UPD_UPTO[profile]) begin
         req.kind = REQ_UPDATE;
      end else begin
         req.kind = REQ_LIST;
      end
      req.ticket = $urandom_range(0, 1) ? TICKET_W'($urandom_range(0, 15))
                                        : TICKET_W'($urandom);
      if (req.kind == REQ_UPDATE && board.fill != 0 && $urandom_range(0, 9) < 7) begin
         req.ticket = board.ticket_at($urandom_range(0, board.fill - 1));
      end
      req.name = {$urandom, $urandom};
      req.date = DATE_W'($urandom);
      case ($urandom_range(0, 15))
         0: begin
            req.name = '0;
            req.date = '0;
         end
         1: begin
            req.name = '1;
            req.date = '1;
         end
         default: ;
      endcase
      return req;
   endfunction

   // Main stimulus: directed checks first, then four random phases that
   // alternate stack and queue order.
   initial begin
      int unsigned phase;
      int unsigned n;
      int unsigned profile;
      board = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_order(1'b0);

      // Stack order. List, remove and update on an empty buffer each report empty.
      send_fields(REQ_LIST, '0, '0, '0);
      send_fields(REQ_REMOVE, '0, '0, '0);
      send_fields(REQ_UPDATE, '0, '0, '0);
      // Field extremes, then a second record with ticket 0 on top, so the
      // update by ticket 0 has to pick the first match from the head.
      send_fields(REQ_ADD, '0, '0, '0);
      send_fields(REQ_ADD, '1, '1, '1);
      send_fields(REQ_ADD, '0, 64'h4142_4344_4546_4748, 23'h0A_5A5A);
      send_fields(REQ_UPDATE, '0, 64'h5A5A_A5A5_0F0F_F0F0, 23'h55_5555);
      send_fields(REQ_UPDATE, '1, 64'h0123_4567_89AB_CDEF, 23'h2A_AAAA);
      send_fields(REQ_UPDATE, 16'h1234, '1, '1);
      send_fields(REQ_LIST, '0, '0, '0);
      send_fields(REQ_REMOVE, '0, '0, '0);

      // Queue order on the two records left behind; the head now sits near
      // the top of the store, so filling up wraps the circular positions.
      settle();
      write_order(1'b1);
      for (n = 0; n < DEPTH - 2; n++) begin
         send_fields(REQ_ADD, TICKET_W'($urandom), {$urandom, $urandom}, DATE_W'($urandom));
      end
      send_fields(REQ_ADD, 16'hBEEF, '1, '1);
      send_fields(REQ_UPDATE, board.ticket_at(board.fill - 1), {$urandom, $urandom},
                  DATE_W'($urandom));
      send_fields(REQ_LIST, '0, '0, '0);
      send_fields(REQ_REMOVE, '0, '0, '0);

      // Random traffic in blocks of twelve beats that fill, drain or mix.
      // The second phase runs with no gaps at all; the third asks the
      // response side for a long hold-off so the block backs up its input.
      for (phase = 0; phase < 4; phase++) begin
         settle();
         write_order(phase[0]);
         no_idle = (phase == 1);
         for (n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 12 == 0) begin
               profile = $urandom_range(0, 2);
            end
            if (phase == 2 && n == 6) begin
               hold_rsp = 1'b1;
            end
            send_request(random_request(profile));
         end
      end
      no_idle = 1'b0;
      settle();

      if (board.mismatches == 0 && board.awaited.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Response side: ready comes in runs, broken by random gaps, plus one
   // long hold-off counted here when the stimulus asks for it.
   initial begin
      int unsigned run;
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         run = no_idle ? 16 : $urandom_range(1, 10);
         rsp_ready <= 1'b1;
         repeat (run) @(posedge clock);
         gap = pick_gap();
         if (gap != 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   // Every response beat taken at a rising edge goes to the scoreboard.
   always @(posedge clock) begin
      rsp_beat_type seen;
      if (!reset && rsp_valid && rsp_ready) begin
         seen.status = status_code_type'(rsp_status);
         seen.ticket = rsp_ticket_out;
         seen.name   = rsp_name_out;
         seen.date   = rsp_date_out;
         seen.last   = rsp_last_item;
         board.check_response(seen);
      end
   end

   // Watchdog: too long without a beat on either channel means a hang.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == IDLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
